// File: rtl/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics accumulator package
// Widths, statistic kind codes and the types shared between the blocks.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int SAMPLE_WIDTH  = 32;
   localparam int FRACTION_BITS = 16;
   localparam int STAT_WIDTH    = 64;
   localparam int COUNT_WIDTH   = 32;
   localparam int KIND_WIDTH    = 3;
   localparam int NUM_KINDS     = 6;

   localparam logic [KIND_WIDTH-1:0] KIND_COUNT  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SUM    = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_MEAN   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_MIN    = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_MAX    = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_STDDEV = 3'd5;

   // Half of one unit in the last place, zero when there are no fraction bits.
   localparam logic [STAT_WIDTH-1:0] HALF_ROUND = (64'd1 << FRACTION_BITS) >> 1;
   localparam logic [STAT_WIDTH-1:0] SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [STAT_WIDTH-1:0] SUM_MIN    = 64'h8000_0000_0000_0000;

   localparam int DIV_STEPS    = 64;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int SQRT_STEPS   = 48;
   localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
   localparam int RAD_WIDTH    = 2 * SQRT_STEPS;
   localparam int SQ_REM_WIDTH = SQRT_STEPS + 4;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic                           is_flush;
      logic signed [SAMPLE_WIDTH-1:0] value;
   } item_type;

   typedef struct packed {
      logic                    start;
      logic [STAT_WIDTH-1:0]   dividend;
      logic [COUNT_WIDTH-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [STAT_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/rsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics front end
// Accepts request words, drops samples marked invalid, queues the rest.
// ----------------------------------------------------------------------------
module rsa_front import rsa_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic signed [31:0] req_sample_value,
   input  logic        req_sample_valid,
   input  logic        fifo_full,
   output logic        push,
   output item_type    push_item
);

   assign req_ready = !fifo_full;

   // An invalid sample is accepted but has no effect, so it is never queued.
   assign push = req_valid && !fifo_full && (req_mode || req_sample_valid);

   assign push_item.is_flush = req_mode;
   assign push_item.value    = req_sample_value[SAMPLE_WIDTH-1:0];

endmodule

// File: rtl/rsa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics item queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rsa_fifo import rsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   item_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]    fill_ff, fill_in;

   assign full      = (fill_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/rsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics divider
// Unsigned 64 by 32 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsa_div import rsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [STAT_WIDTH-1:0]  quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] dvs_ff, dvs_in;
   logic [COUNT_WIDTH:0]   rem_trial;

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      rem_trial = {rem_ff, quo_ff[STAT_WIDTH-1]};
      if (busy_ff) begin
         if (rem_trial >= {1'b0, dvs_ff}) begin
            rem_in = COUNT_WIDTH'(rem_trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[STAT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_trial[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[STAT_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

// File: rtl/rsa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics back end
// Accumulates samples, and on a flush derives and emits the statistics.
// ----------------------------------------------------------------------------
module rsa_back import rsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [NUM_KINDS-1:0]   csr_wdata,
   input  logic                   head_valid,
   input  item_type               head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [KIND_WIDTH-1:0]  rsp_stat_kind,
   output logic signed [STAT_WIDTH-1:0] rsp_stat_value,
   output logic                   rsp_last_stat
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MEAN_WAIT = 4'd1;
   localparam logic [3:0] ST_MSQ_LO    = 4'd2;
   localparam logic [3:0] ST_MSQ_HI    = 4'd3;
   localparam logic [3:0] ST_MSQ_SUM   = 4'd4;
   localparam logic [3:0] ST_QS_WAIT   = 4'd5;
   localparam logic [3:0] ST_SQRT      = 4'd6;
   localparam logic [3:0] ST_EMIT      = 4'd7;

   localparam int HALF_W = STAT_WIDTH / 2;

   logic [3:0] state_ff, state_in;
   logic [NUM_KINDS-1:0] enable_ff, enable_in;
   logic [NUM_KINDS-1:0] mask_ff, mask_in;

   // Sample pipeline stage: the square is formed here, added next cycle.
   logic stg_valid_ff, stg_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] stg_x_ff, stg_x_in;
   logic [2*SAMPLE_WIDTH-1:0] stg_prod_ff, stg_prod_in;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [STAT_WIDTH-1:0]  sum_ff, sum_in;
   logic [STAT_WIDTH-1:0]  sumsq_ff, sumsq_in;
   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in;

   logic [STAT_WIDTH-1:0] mmag_ff, mmag_in;
   logic [STAT_WIDTH-1:0] mean_ff, mean_in;
   logic [STAT_WIDTH-1:0] p0_ff, p0_in;
   logic [STAT_WIDTH-1:0] p1_ff, p1_in;
   logic [STAT_WIDTH-1:0] msq_ff, msq_in;
   logic [RAD_WIDTH-1:0]  rad_ff, rad_in;
   logic [SQ_REM_WIDTH-1:0] srem_ff, srem_in;
   logic [SQRT_STEPS-1:0] root_ff, root_in;
   logic [SQRT_CNT_W-1:0] sstep_ff, sstep_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [KIND_WIDTH-1:0] kind_ff, kind_in;
   logic [STAT_WIDTH-1:0] value_ff, value_in;
   logic last_ff, last_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [SAMPLE_WIDTH-1:0]   head_mag;
   logic [STAT_WIDTH-1:0]     x_ext;
   logic [STAT_WIDTH:0]       sum_wide;
   logic [STAT_WIDTH-1:0]     sq;
   logic [STAT_WIDTH:0]       sumsq_wide;
   logic [STAT_WIDTH-1:0]     smag;
   logic [STAT_WIDTH-1:0]     var_val;
   logic [SQ_REM_WIDTH-1:0]   srem_trial;
   logic [SQ_REM_WIDTH-1:0]   strial;
   logic                      out_free;
   logic [KIND_WIDTH-1:0]     pick;
   logic [NUM_KINDS-1:0]      pick_bit;

   rsa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stat_kind  = kind_ff;
   assign rsp_stat_value = value_ff;
   assign rsp_last_stat  = last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // A flush waits until the sample stage has drained into the statistics.
   assign pop = (state_ff == ST_IDLE) && head_valid &&
                (!head_item.is_flush || !stg_valid_ff);

   assign head_mag = head_item.value[SAMPLE_WIDTH-1] ?
                     (~head_item.value + 1'b1) : head_item.value;
   assign smag     = sum_ff[STAT_WIDTH-1] ? (~sum_ff + 1'b1) : sum_ff;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = smag;
      div_req.divisor  = count_ff;
      if (state_ff == ST_IDLE && pop && head_item.is_flush && count_ff != '0) begin
         div_req.start = 1'b1;
      end
      if (state_ff == ST_MSQ_SUM) begin
         div_req.start    = 1'b1;
         div_req.dividend = sumsq_ff;
      end
   end

   // Lowest pending statistic goes out first.
   always_comb begin
      pick     = KIND_COUNT;
      pick_bit = '0;
      for (int i = NUM_KINDS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick     = KIND_WIDTH'(i);
            pick_bit = '0;
            pick_bit[i] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      enable_in    = csr_we ? csr_wdata : enable_ff;
      mask_in      = mask_ff;
      stg_valid_in = 1'b0;
      stg_x_in     = head_item.value;
      stg_prod_in  = head_mag * head_mag;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mmag_in      = mmag_ff;
      mean_in      = mean_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      msq_in       = msq_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      sstep_in     = sstep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      x_ext      = STAT_WIDTH'(stg_x_ff);
      sum_wide   = {sum_ff[STAT_WIDTH-1], sum_ff} + {x_ext[STAT_WIDTH-1], x_ext};
      sq         = (STAT_WIDTH'(stg_prod_ff) + HALF_ROUND) >> FRACTION_BITS;
      sumsq_wide = {1'b0, sumsq_ff} + {1'b0, sq};
      var_val    = (div_rsp.quotient > msq_ff) ? div_rsp.quotient - msq_ff : '0;
      srem_trial = {srem_ff[SQ_REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
      strial     = SQ_REM_WIDTH'({root_ff, 2'b01});

      // Accumulate the sample held in the stage.
      if (stg_valid_ff) begin
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
         if (sum_wide[STAT_WIDTH] != sum_wide[STAT_WIDTH-1]) begin
            sum_in = sum_wide[STAT_WIDTH] ? SUM_MIN : SUM_MAX;
         end else begin
            sum_in = sum_wide[STAT_WIDTH-1:0];
         end
         sumsq_in = (sumsq_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sumsq_wide[STAT_WIDTH-1:0];
         if (count_ff == '0 || stg_x_ff < min_ff) begin
            min_in = stg_x_ff;
         end
         if (count_ff == '0 || stg_x_ff > max_ff) begin
            max_in = stg_x_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head_item.is_flush) begin
                  mask_in = {(count_ff != '0) ? enable_ff[NUM_KINDS-1:1] : 5'b0,
                             enable_ff[0]};
                  state_in = (count_ff != '0) ? ST_MEAN_WAIT : ST_EMIT;
               end else begin
                  stg_valid_in = 1'b1;
               end
            end
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mmag_in  = div_rsp.quotient;
               mean_in  = sum_ff[STAT_WIDTH-1] ? (~div_rsp.quotient + 1'b1)
                                               : div_rsp.quotient;
               state_in = ST_MSQ_LO;
            end
         end
         ST_MSQ_LO: begin
            p0_in    = mmag_ff[HALF_W-1:0] * mmag_ff[HALF_W-1:0];
            state_in = ST_MSQ_HI;
         end
         ST_MSQ_HI: begin
            p1_in    = mmag_ff[HALF_W-1:0] * mmag_ff[STAT_WIDTH-1:HALF_W];
            state_in = ST_MSQ_SUM;
         end
         ST_MSQ_SUM: begin
            // Low word of the mean squared: the cross term counts twice.
            msq_in   = (p0_ff + (p1_ff << (HALF_W + 1)) + HALF_ROUND) >> FRACTION_BITS;
            state_in = ST_QS_WAIT;
         end
         ST_QS_WAIT: begin
            if (div_rsp.done) begin
               rad_in   = RAD_WIDTH'(var_val) << FRACTION_BITS;
               srem_in  = '0;
               root_in  = '0;
               sstep_in = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (srem_trial >= strial) begin
               srem_in = srem_trial - strial;
               root_in = {root_ff[SQRT_STEPS-2:0], 1'b1};
            end else begin
               srem_in = srem_trial;
               root_in = {root_ff[SQRT_STEPS-2:0], 1'b0};
            end
            rad_in   = rad_ff << 2;
            sstep_in = sstep_ff + 1'b1;
            if (sstep_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (mask_ff == '0) begin
               count_in = '0;
               sum_in   = '0;
               sumsq_in = '0;
               min_in   = '0;
               max_in   = '0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = pick;
               last_in      = ((mask_ff & ~pick_bit) == '0);
               mask_in      = mask_ff & ~pick_bit;
               unique case (pick)
                  KIND_COUNT:  value_in = STAT_WIDTH'(count_ff);
                  KIND_SUM:    value_in = sum_ff;
                  KIND_MEAN:   value_in = mean_ff;
                  KIND_MIN:    value_in = STAT_WIDTH'(min_ff);
                  KIND_MAX:    value_in = STAT_WIDTH'(max_ff);
                  KIND_STDDEV: value_in = STAT_WIDTH'(root_ff);
                  default:     value_in = '0;
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= '1;
         mask_ff      <= '0;
         stg_valid_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         mask_ff      <= mask_in;
         stg_valid_ff <= stg_valid_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stg_x_ff    <= stg_x_in;
      stg_prod_ff <= stg_prod_in;
      mmag_ff     <= mmag_in;
      mean_ff     <= mean_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      msq_ff      <= msq_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      sstep_ff    <= sstep_in;
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
   end

endmodule

// File: rtl/running_stats_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics accumulator
// Count, sum, mean, min, max and standard deviation of a fixed-point stream.
// ----------------------------------------------------------------------------
// The request channel carries one word per sample or flush. A sample word
// with req_sample_valid low is taken and ignored. Valid samples are queued,
// squared into the sample stage and folded into the running statistics in
// the next cycle, so the block sustains one sample word per cycle while no
// flush is in progress. A flush word waits for the sample pipeline to drain,
// then runs the shared divider for the mean, the MSQ_LO, MSQ_HI and MSQ_SUM
// states for the squared mean, the divider again for the mean square and a
// 48-step square root when the count is non-zero. The enabled statistics
// (only the count when the count is zero) then leave on the response channel
// in kind order, one word per cycle while the receiver is ready, with
// rsp_last_stat on the final word; the statistics clear.
// While the receiver stalls, the response register holds its word and the
// four-entry queue keeps accepting words until it fills.
// csr_we writes the six-bit enable mask (reset all ones).
// Synchronous reset clears the statistics, the queue and the response.
// ----------------------------------------------------------------------------
module running_stats_accumulator import rsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic signed [31:0] req_sample_value,
   input  logic        req_sample_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_stat_kind,
   output logic signed [63:0] rsp_stat_value,
   output logic        rsp_last_stat
);

   // Queue handshake between the front and back ends.
   logic     push;
   logic     pop;
   logic     fifo_full;
   logic     fifo_empty;
   item_type push_item;
   item_type head_item;

   // The front end classifies each word and drops invalid samples.
   rsa_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample_value (req_sample_value),
      .req_sample_valid (req_sample_valid),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_item        (push_item)
   );

   rsa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .empty     (fifo_empty),
      .head_item (head_item)
   );

   // The back end owns the statistics, the divider and the square root.
   rsa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .head_valid     (!fifo_empty),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_stat_kind  (rsp_stat_kind),
      .rsp_stat_value (rsp_stat_value),
      .rsp_last_stat  (rsp_last_stat)
   );

endmodule

// File: verif/tb_running_stats_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics accumulator testbench
// Drives sample and flush words into the accumulator, predicts every
// statistic word that a flush emits and compares the response stream
// field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_running_stats_accumulator;
   import rsa_pkg::*;

   // One request word as the driver presents it. A word marked wait_drain is
   // held back until every expected statistic has come out of the block.
   typedef struct {
      logic                     mode;
      logic signed [31:0]       value;
      logic                     valid;
      logic                     wait_drain;
   } req_word_type;

   // One statistic word as the block should emit it.
   typedef struct {
      logic [KIND_WIDTH-1:0]    kind;
      logic signed [63:0]       value;
      logic                     last;
   } stat_word_type;

   // Time for a full queue of flushes plus the one in progress to work
   // through the divider and the square root, with margin. Used before
   // register writes and at the end of the run.
   localparam int SETTLE_CYCLES = 1200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [5:0]         csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = 1'b0;
   logic signed [31:0] req_sample_value = '0;
   logic               req_sample_valid = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_stat_kind;
   logic signed [63:0] rsp_stat_value;
   logic               rsp_last_stat;

   req_word_type  pending_words[$];
   stat_word_type expected_stats[$];

   int  error_count = 0;
   int  samples_sent = 0;
   int  flushes_sent = 0;
   int  stats_checked = 0;
   int  rsp_hold_cycles = 0;
   bit  rsp_idle_enable = 1'b1;

   // The predictor's own copy of the block's registers and statistics.
   logic [5:0]         enable_mask;
   logic [31:0]        acc_count;
   logic signed [63:0] acc_sum;
   logic [63:0]        acc_square_sum;
   logic signed [31:0] acc_min;
   logic signed [31:0] acc_max;

   running_stats_accumulator u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample_value (req_sample_value),
      .req_sample_valid (req_sample_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stat_kind    (rsp_stat_kind),
      .rsp_stat_value   (rsp_stat_value),
      .rsp_last_stat    (rsp_last_stat)
   );

   always #5 clock = ~clock;

   // Mostly back to back, sometimes a short gap, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      error_count++;
   endtask

   task automatic clear_accumulators();
      acc_count      = '0;
      acc_sum        = '0;
      acc_square_sum = '0;
      acc_min        = '0;
      acc_max        = '0;
   endtask

   // Floor of the square root of v scaled up by the fraction bits.
   function automatic logic [63:0] fixed_root(input logic [63:0] v);
      logic [127:0] target;
      logic [127:0] trial;
      logic [63:0]  root;
      target = {64'd0, v} << FRACTION_BITS;
      root   = '0;
      for (int b = 47; b >= 0; b--) begin
         trial = {64'd0, root | (64'd1 << b)};
         if (trial * trial <= target) begin
            root = trial[63:0];
         end
      end
      return root;
   endfunction

   // Folds one accepted word into the prediction. A flush queues the enabled
   // statistics in kind order and marks the final one.
   task automatic predict_word(input req_word_type w);
      logic signed [64:0] wide_sum;
      logic [63:0]        mag, square, sum_mag, mean_mag, mean_sq, mean_of_sq, variance;
      logic               neg;
      stat_word_type      outs[$];
      stat_word_type      s;
      if (w.mode == 1'b0) begin
         if (!w.valid) return;
         if (acc_count != 32'hFFFF_FFFF) acc_count = acc_count + 1;
         wide_sum = {acc_sum[63], acc_sum} + 65'(w.value);
         if (wide_sum[64] != wide_sum[63]) begin
            acc_sum = wide_sum[64] ? SUM_MIN : SUM_MAX;
         end else begin
            acc_sum = wide_sum[63:0];
         end
         mag    = (w.value < 0) ? -64'(w.value) : 64'(w.value);
         square = (mag * mag + HALF_ROUND) >> FRACTION_BITS;
         if (acc_square_sum > SUM_MAX - square) begin
            acc_square_sum = SUM_MAX;
         end else begin
            acc_square_sum = acc_square_sum + square;
         end
         if (acc_count == 1 || w.value < acc_min) acc_min = w.value;
         if (acc_count == 1 || w.value > acc_max) acc_max = w.value;
         return;
      end
      s.last = 1'b0;
      if (enable_mask[0]) begin
         s.kind = KIND_COUNT; s.value = {32'd0, acc_count}; outs.push_back(s);
      end
      if (acc_count != 0) begin
         neg      = acc_sum < 0;
         sum_mag  = neg ? -acc_sum : acc_sum;
         mean_mag = sum_mag / {32'd0, acc_count};
         if (enable_mask[1]) begin
            s.kind = KIND_SUM; s.value = acc_sum; outs.push_back(s);
         end
         if (enable_mask[2]) begin
            s.kind = KIND_MEAN; s.value = neg ? -mean_mag : mean_mag; outs.push_back(s);
         end
         if (enable_mask[3]) begin
            s.kind = KIND_MIN; s.value = 64'(acc_min); outs.push_back(s);
         end
         if (enable_mask[4]) begin
            s.kind = KIND_MAX; s.value = 64'(acc_max); outs.push_back(s);
         end
         if (enable_mask[5]) begin
            // The squared mean wraps at 64 bits before rounding, as the
            // block's datapath does.
            mean_sq    = (mean_mag * mean_mag + HALF_ROUND) >> FRACTION_BITS;
            mean_of_sq = acc_square_sum / {32'd0, acc_count};
            variance   = (mean_of_sq > mean_sq) ? mean_of_sq - mean_sq : 64'd0;
            s.kind = KIND_STDDEV; s.value = fixed_root(variance); outs.push_back(s);
         end
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) expected_stats.push_back(outs[i]);
      clear_accumulators();
   endtask

   // Driver: presents pending words with random gaps. The payload stays put
   // while valid is high and not yet accepted.
   int drive_gap = 0;
   always @(posedge clock) begin
      req_word_type w;
      if (!reset) begin
         if (req_valid && req_ready) begin
            w.mode  = req_mode;
            w.value = req_sample_value;
            w.valid = req_sample_valid;
            predict_word(w);
            if (req_mode) flushes_sent++; else samples_sent++;
         end
         if (!req_valid || req_ready) begin
            if (drive_gap > 0) begin
               drive_gap <= drive_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].wait_drain && expected_stats.size() > 0)) begin
               w = pending_words.pop_front();
               req_valid        <= 1'b1;
               req_mode         <= w.mode;
               req_sample_value <= w.value;
               req_sample_valid <= w.valid;
               drive_gap        <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when one is requested.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_enable) begin
         rsp_ready <= ($urandom_range(0, 99) < 70);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: every accepted statistic word is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      stat_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stats.size() == 0) begin
            $display("[%0t] unexpected statistic word kind %0d value %0h",
                     $realtime, rsp_stat_kind, rsp_stat_value);
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            stats_checked++;
            if (rsp_stat_kind !== want.kind)
               report_mismatch("stat_kind", 64'(want.kind), 64'(rsp_stat_kind));
            if (rsp_stat_value !== want.value)
               report_mismatch("stat_value", want.value, rsp_stat_value);
            if (rsp_last_stat !== want.last)
               report_mismatch("last_stat", 64'(want.last), 64'(rsp_last_stat));
         end
      end
   end

   task automatic queue_word(input logic mode, input logic signed [31:0] value,
                             input logic valid, input bit wait_drain = 0);
      req_word_type w;
      w.mode = mode; w.value = value; w.valid = valid; w.wait_drain = wait_drain;
      pending_words.push_back(w);
   endtask

   function automatic logic signed [31:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      if (roll < 4) return $signed(32'($urandom_range(0, 600))) - 300;
      if (roll < 6) return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      return $signed($urandom());
   endfunction

   // A well-formed burst: some samples, a few of them marked invalid, then a
   // flush with random don't-care fields.
   task automatic queue_burst(input int max_len, input bit wait_drain = 0);
      int len;
      len = $urandom_range(0, max_len);
      for (int i = 0; i < len; i++)
         queue_word(1'b0, pick_sample(), ($urandom_range(0, 9) != 0), wait_drain && i == 0);
      queue_word(1'b1, $signed($urandom()), 1'($urandom()), wait_drain && len == 0);
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable_mask(input logic [5:0] mask);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= mask;
      @(posedge clock);
      csr_we    <= 1'b0;
      enable_mask = mask;
   endtask

   initial begin
      #200_000_000;
      $display("running_stats_accumulator verification failed");
      $finish;
   end

   initial begin
      logic [5:0] masks[4];
      enable_mask = 6'h3F;
      clear_accumulators();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: flush of nothing, the field extremes, an ignored sample,
      // a lone most-negative sample and small values near the rounding point.
      queue_word(1'b1, 32'sh0, 1'b0);
      queue_word(1'b0, 32'sh7FFF_FFFF, 1'b1);
      queue_word(1'b0, 32'sh8000_0000, 1'b1);
      queue_word(1'b0, 32'sh0, 1'b1);
      queue_word(1'b0, -32'sd1, 1'b1);
      queue_word(1'b0, 32'sh5555_5555, 1'b0);
      queue_word(1'b1, -32'sd1, 1'b1);
      queue_word(1'b0, 32'sh8000_0000, 1'b1);
      queue_word(1'b1, 32'sh0, 1'b0);
      queue_word(1'b0, 32'sd182, 1'b1);
      queue_word(1'b0, 32'sd180, 1'b1);
      queue_word(1'b0, 32'sd181, 1'b1);
      queue_word(1'b1, 32'sh0, 1'b1);
      queue_word(1'b0, 32'sh0001_0000, 1'b1);
      queue_word(1'b0, -32'sh0003_8000, 1'b1);
      queue_word(1'b0, 32'sh7FFF_FFFF, 1'b1);
      queue_word(1'b0, 32'sh7FFF_FFFF, 1'b1);
      queue_word(1'b1, 32'sh7FFF_FFFF, 1'b0);
      queue_word(1'b0, -32'sd7, 1'b0);
      queue_word(1'b1, 32'sh0, 1'b1);

      // Nothing enabled, then count alone: flushes may emit no words at all.
      write_enable_mask(6'h00);
      queue_word(1'b0, 32'sh1234_5678, 1'b1);
      queue_word(1'b1, 32'sh0, 1'b0);
      write_enable_mask(6'h01);
      queue_word(1'b1, 32'sh0, 1'b0);
      queue_word(1'b0, -32'sh0000_0100, 1'b1);
      queue_word(1'b1, 32'sh0, 1'b0);

      // Back to everything enabled. The receiver holds off for a long
      // stretch while flushes pile up and the block stalls its input.
      write_enable_mask(6'h3F);
      rsp_hold_cycles = 600;
      for (int i = 0; i < 12; i++) queue_burst(2);

      // Random phases over several masks. Some bursts wait for the block to
      // drain completely first; one phase runs without any receiver stalls.
      masks[0] = 6'h3F; masks[1] = 6'h20; masks[2] = 6'($urandom()); masks[3] = 6'h3F;
      for (int p = 0; p < 4; p++) begin
         write_enable_mask(masks[p]);
         rsp_idle_enable = (p != 1);
         for (int i = 0; i < 10; i++) queue_burst(10, (i % 4) == 3);
         queue_word(1'b0, pick_sample(), 1'b0);
      end

      wait_idle();
      $display("Sent %0d samples and %0d flushes; checked %0d statistic words.",
               samples_sent, flushes_sent, stats_checked);
      $display("Masks included all, none, count only and stddev only, with long stalls.");
      if (error_count == 0) begin
         $display("running_stats_accumulator verification clean");
      end else begin
         $display("running_stats_accumulator verification failed");
      end
      $finish;
   end

endmodule
